### src/wstd_pkg.sv
// Shared types and constants for the WebSocket text deframer.
package wstd_pkg;

  // Result kinds carried on the output tuser bits.
  typedef enum logic [1:0] {
    KIND_DATA  = 2'd0,
    KIND_EMPTY = 2'd1,
    KIND_ERROR = 2'd2
  } kind_t;

  // Header constants of the frame format.
  localparam logic [3:0] OPCODE_TEXT = 4'h1;
  localparam logic [6:0] LEN_EXT16   = 7'd126;
  localparam logic [6:0] LEN_EXT64   = 7'd127;
  localparam logic [2:0] EXT16_LAST  = 3'd1;
  localparam logic [2:0] EXT64_LAST  = 3'd7;
  localparam logic [2:0] KEY_LAST    = 3'd3;

  // Depth of the queue between parser and output stage.
  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

  // One classified result waiting for the output stage.
  typedef struct packed {
    kind_t       kind;
    logic [7:0]  data;
    logic [7:0]  key;
    logic        last;
  } entry_t;

endpackage

### src/websocket_text_deframer_unit.sv
// Top level of the WebSocket text frame deframer.
//
// Input channel in_*: one received byte per transaction in in_tdata.
// Output channel out_*: one result per transaction. out_tuser holds the
// kind (payload byte, empty frame complete, or non-text opcode error),
// out_tdata the unmasked payload byte (zero for other kinds) and out_tlast
// marks the result that completes a frame.
// Header bytes produce no result, except the one that ends an empty frame
// or holds a non-text opcode; each payload byte produces one. An accepted
// payload byte is written into the queue, then into the output register.
// Throughput is one byte per cycle while in_tready is high, set by the
// header parser and its 64-bit length counter. A four-entry queue sits
// between the parser and the output register, so the input keeps flowing
// while the receiver stalls until the queue fills; in_tready then drops.
// Reset returns the parser to the first header byte and empties the queue.
// After a non-text opcode the block reports one error result and then
// accepts and drops every byte until reset.
module websocket_text_deframer_unit
  import wstd_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // [7:0] rx_byte
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,  // [7:0] payload_byte
  output logic [1:0] out_tuser,  // [1:0] kind
  output logic       out_tlast
);

  logic   in_fire;
  logic   push;
  entry_t push_data;
  logic   pop;
  entry_t pop_data;
  logic   q_full;
  logic   q_empty;

  assign in_tready = !q_full;
  assign in_fire   = in_tvalid && in_tready;

  wstd_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_fire (in_fire),
    .in_byte (in_tdata),
    .push_o  (push),
    .entry_o (push_data)
  );

  wstd_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .pop_data  (pop_data),
    .full      (q_full),
    .empty     (q_empty)
  );

  wstd_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_empty    (q_empty),
    .q_data     (pop_data),
    .q_pop      (pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

endmodule

### src/wstd_front.sv
// Frame header parser: classifies each received byte and queues results.
module wstd_front
  import wstd_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_fire,
  input  logic [7:0] in_byte,
  output logic       push_o,
  output entry_t     entry_o
);

  typedef enum logic [2:0] {
    PH_HDR0,
    PH_HDR1,
    PH_EXT,
    PH_KEY,
    PH_DATA
  } phase_t;

  phase_t      phase_r, phase_nxt;
  logic        mask_r, mask_nxt;
  logic [63:0] rem_r, rem_nxt;
  logic [2:0]  cnt_r, cnt_nxt;
  logic [31:0] key_r, key_nxt;
  logic [1:0]  kidx_r, kidx_nxt;
  logic        halted_r, halted_nxt;
  logic        long_r, long_nxt;

  logic [63:0] rem_shift;
  logic [2:0]  ext_last;
  logic        rem_le1;

  assign rem_shift = {rem_r[55:0], in_byte};
  assign ext_last  = long_r ? EXT64_LAST : EXT16_LAST;
  assign rem_le1   = (rem_r[63:1] == 63'd0);

  // Next-state and result decode for one accepted byte.
  always_comb begin
    phase_nxt  = phase_r;
    mask_nxt   = mask_r;
    rem_nxt    = rem_r;
    cnt_nxt    = cnt_r;
    key_nxt    = key_r;
    kidx_nxt   = kidx_r;
    halted_nxt = halted_r;
    long_nxt   = long_r;
    push_o     = 1'b0;
    entry_o    = '{kind: KIND_DATA, data: 8'd0, key: 8'd0, last: 1'b0};
    if (in_fire && !halted_r) begin
      unique case (phase_r)
        PH_HDR0: begin
          if (in_byte[3:0] != OPCODE_TEXT) begin
            halted_nxt   = 1'b1;
            push_o       = 1'b1;
            entry_o.kind = KIND_ERROR;
          end else begin
            phase_nxt = PH_HDR1;
          end
        end
        PH_HDR1: begin
          mask_nxt = in_byte[7];
          key_nxt  = 32'd0;
          if (in_byte[6:0] == LEN_EXT16 || in_byte[6:0] == LEN_EXT64) begin
            long_nxt  = (in_byte[6:0] == LEN_EXT64);
            rem_nxt   = 64'd0;
            cnt_nxt   = 3'd0;
            phase_nxt = PH_EXT;
          end else begin
            rem_nxt  = {57'd0, in_byte[6:0]};
            cnt_nxt  = 3'd0;
            kidx_nxt = 2'd0;
            if (in_byte[7]) begin
              phase_nxt = PH_KEY;
            end else if (in_byte[6:0] == 7'd0) begin
              phase_nxt     = PH_HDR0;
              push_o        = 1'b1;
              entry_o.kind  = KIND_EMPTY;
              entry_o.last  = 1'b1;
            end else begin
              phase_nxt = PH_DATA;
            end
          end
        end
        PH_EXT: begin
          rem_nxt = rem_shift;
          if (cnt_r >= ext_last) begin
            cnt_nxt  = 3'd0;
            kidx_nxt = 2'd0;
            if (mask_r) begin
              phase_nxt = PH_KEY;
            end else if (rem_shift == 64'd0) begin
              phase_nxt    = PH_HDR0;
              push_o       = 1'b1;
              entry_o.kind = KIND_EMPTY;
              entry_o.last = 1'b1;
            end else begin
              phase_nxt = PH_DATA;
            end
          end else begin
            cnt_nxt = cnt_r + 3'd1;
          end
        end
        PH_KEY: begin
          key_nxt[8*cnt_r[1:0] +: 8] = in_byte;
          if (cnt_r >= KEY_LAST) begin
            cnt_nxt  = 3'd0;
            kidx_nxt = 2'd0;
            if (rem_r == 64'd0) begin
              phase_nxt    = PH_HDR0;
              push_o       = 1'b1;
              entry_o.kind = KIND_EMPTY;
              entry_o.last = 1'b1;
            end else begin
              phase_nxt = PH_DATA;
            end
          end else begin
            cnt_nxt = cnt_r + 3'd1;
          end
        end
        PH_DATA: begin
          push_o        = 1'b1;
          entry_o.kind  = KIND_DATA;
          entry_o.data  = in_byte;
          entry_o.key   = mask_r ? key_r[8*kidx_r +: 8] : 8'd0;
          entry_o.last  = rem_le1;
          kidx_nxt      = kidx_r + 2'd1;
          if (rem_r != 64'd0) begin
            rem_nxt = rem_r - 64'd1;
          end
          if (rem_le1) begin
            phase_nxt = PH_HDR0;
            kidx_nxt  = 2'd0;
          end
        end
        default: begin
          phase_nxt = PH_HDR0;
        end
      endcase
    end
  end

  // Parser state registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_HDR0;
      mask_r   <= 1'b0;
      rem_r    <= 64'd0;
      cnt_r    <= 3'd0;
      key_r    <= 32'd0;
      kidx_r   <= 2'd0;
      halted_r <= 1'b0;
      long_r   <= 1'b0;
    end else begin
      phase_r  <= phase_nxt;
      mask_r   <= mask_nxt;
      rem_r    <= rem_nxt;
      cnt_r    <= cnt_nxt;
      key_r    <= key_nxt;
      kidx_r   <= kidx_nxt;
      halted_r <= halted_nxt;
      long_r   <= long_nxt;
    end
  end

  // Once halted, the parser never queues another result.
  a_halt_silent: assert property (@(posedge clk) disable iff (!rst_n)
    halted_r |-> !push_o) else $error("result queued after opcode error");

  // The last payload byte of a frame returns the parser to the first header byte.
  a_last_to_hdr0: assert property (@(posedge clk) disable iff (!rst_n)
    push_o && entry_o.kind == KIND_DATA && entry_o.last |=> phase_r == PH_HDR0)
    else $error("parser did not return to header after frame end");

endmodule

### src/wstd_fifo.sv
// Short queue of classified results between parser and output stage.
module wstd_fifo
  import wstd_pkg::*;
(
  input  logic   clk,
  input  logic   rst_n,
  input  logic   push,
  input  entry_t push_data,
  input  logic   pop,
  output entry_t pop_data,
  output logic   full,
  output logic   empty
);

  entry_t               mem_r [FIFO_DEPTH];
  logic [FIFO_AW-1:0]   wr_ptr_r;
  logic [FIFO_AW-1:0]   rd_ptr_r;
  logic [FIFO_AW:0]     count_r;

  assign full     = (count_r == (FIFO_AW+1)'(FIFO_DEPTH));
  assign empty    = (count_r == '0);
  assign pop_data = mem_r[rd_ptr_r];

  // Entry storage; no reset is needed for the payload.
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      count_r <= count_r + (FIFO_AW+1)'(push) - (FIFO_AW+1)'(pop);
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    full |-> !push) else $error("push into full queue");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    empty |-> !pop) else $error("pop from empty queue");

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= (FIFO_AW+1)'(FIFO_DEPTH)) else $error("queue count out of range");

endmodule

### src/wstd_back.sv
// Output stage: unmasks queued payload bytes into the output register.
module wstd_back
  import wstd_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       q_empty,
  input  entry_t     q_data,
  output logic       q_pop,
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,
  output logic [1:0] out_tuser,
  output logic       out_tlast
);

  logic       valid_r;
  logic [7:0] data_r;
  kind_t      kind_r;
  logic       last_r;

  // Load a new result whenever the register is empty or being drained.
  assign q_pop = !q_empty && (!valid_r || out_tready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (q_pop) begin
      valid_r <= 1'b1;
    end else if (out_tready) begin
      valid_r <= 1'b0;
    end
  end

  // Result payload: key byte is zero for unmasked frames and non-data kinds.
  always_ff @(posedge clk) begin
    if (q_pop) begin
      data_r <= q_data.data ^ q_data.key;
      kind_r <= q_data.kind;
      last_r <= q_data.last;
    end
  end

  assign out_tvalid = valid_r;
  assign out_tdata  = data_r;
  assign out_tuser  = kind_r;
  assign out_tlast  = last_r;

  a_pop_fills: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |=> valid_r) else $error("popped entry not presented");

endmodule
